// ----- hdl/cdq_pkg.sv -----
package cdq_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OCC_W = 4;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic             pop_ok;
    status_t          status;
    logic [CNT_W-1:0] count;
  } result_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(i + 1'b1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(i - 1'b1);
  endfunction

endpackage

// ----- hdl/circular_deque.sv -----
// Channel   Handshake            Payload
// in        start / busy         in_func, in_value
// out       out_valid (strobe)   out_data_out, out_status, out_occupancy
//
// One item per cycle; busy is never raised.
// Each result is registered and appears in the cycle after its item, like the store's registered read port.
// A push written into the store is visible to any pop accepted after it.
// rst_n is synchronous; the store itself is not cleared.
// The receiver cannot stall: each result is shown for one cycle only.
module circular_deque (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic signed [cdq_pkg::WORD_W-1:0] in_value,
  output logic                          out_valid,
  output logic signed [cdq_pkg::WORD_W-1:0] out_data_out,
  output logic [1:0]                    out_status,
  output logic [cdq_pkg::OCC_W-1:0]     out_occupancy
);
  import cdq_pkg::*;

  logic                     accept;
  mem_req_t                 mem_req;
  result_t                  result;
  logic [WORD_W-1:0]        rd_data;
  logic [CNT_W+OCC_W-1:0]   occ_wide;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  cdq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .func    (op_t'(in_func)),
    .value   (in_value),
    .mem_req (mem_req),
    .result  (result)
  );

  cdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.addr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.addr),
    .rdata (rd_data)
  );

  assign occ_wide      = {{OCC_W{1'b0}}, result.count};
  assign out_valid     = result.valid;
  assign out_data_out  = result.pop_ok ? rd_data : '0;
  assign out_status    = result.status;
  assign out_occupancy = occ_wide[OCC_W-1:0];

`ifndef SYNTHESIS
  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("item gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without an item");

  a_empty_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> result.count == '0 && out_data_out == '0)
    else $error("empty refusal with words held");

  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> result.count == CNT_W'(DEPTH))
    else $error("full refusal on a queue that is not full");

  a_no_pop_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> !mem_req.re)
    else $error("store written and read by one item");
`endif

endmodule

// ----- hdl/cdq_ram.sv -----
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/cdq_ctrl.sv -----
module cdq_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  cdq_pkg::op_t                  func,
  input  logic [cdq_pkg::WORD_W-1:0]    value,
  output cdq_pkg::mem_req_t             mem_req,
  output cdq_pkg::result_t              result
);
  import cdq_pkg::*;

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] rear_r, rear_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             valid_r, valid_nxt;
  logic             pop_ok_r, pop_ok_nxt;
  status_t          status_r, status_nxt;
  logic             empty, full;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));

  always_comb begin
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    count_nxt     = count_r;
    status_nxt    = ST_DONE;
    pop_ok_nxt    = 1'b0;
    valid_nxt     = accept;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = '0;
    mem_req.wdata = value;
    if (accept) begin
      unique case (func)
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          priority if (full) begin
            status_nxt = ST_FULL;
          end else if (empty) begin
            front_nxt  = '0;
            rear_nxt   = '0;
            count_nxt  = CNT_W'(1);
            mem_req.we = 1'b1;
          end else if (func == OP_PUSH_FRONT) begin
            front_nxt    = idx_dec(front_r);
            mem_req.addr = idx_dec(front_r);
            mem_req.we   = 1'b1;
            count_nxt    = CNT_W'(count_r + 1'b1);
          end else begin
            rear_nxt     = idx_inc(rear_r);
            mem_req.addr = idx_inc(rear_r);
            mem_req.we   = 1'b1;
            count_nxt    = CNT_W'(count_r + 1'b1);
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            mem_req.re   = 1'b1;
            mem_req.addr = (func == OP_POP_FRONT) ? front_r : rear_r;
            pop_ok_nxt   = 1'b1;
            count_nxt    = CNT_W'(count_r - 1'b1);
            priority if (count_r == CNT_W'(1)) begin
              front_nxt = '0;
              rear_nxt  = '0;
            end else if (func == OP_POP_FRONT) begin
              front_nxt = idx_inc(front_r);
            end else begin
              rear_nxt = idx_dec(rear_r);
            end
          end
        end
        default: begin
          status_nxt = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r  <= '0;
      rear_r   <= '0;
      count_r  <= '0;
      valid_r  <= 1'b0;
      pop_ok_r <= 1'b0;
      status_r <= ST_DONE;
    end else begin
      front_r  <= front_nxt;
      rear_r   <= rear_nxt;
      count_r  <= count_nxt;
      valid_r  <= valid_nxt;
      pop_ok_r <= pop_ok_nxt;
      status_r <= status_nxt;
    end
  end

  assign result.valid  = valid_r;
  assign result.pop_ok = pop_ok_r;
  assign result.status = status_r;
  assign result.count  = count_r;

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  typedef struct {
    logic signed [WORD_W-1:0] data;
    status_t                  status;
    logic [OCC_W-1:0]         occ;
  } deque_result_t;

  typedef struct {
    op_t                      op;
    logic signed [WORD_W-1:0] value;
    bit                       fixed;
    deque_result_t            result;
  } deque_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [1:0]               in_func = '0;
  logic signed [WORD_W-1:0] in_value = '0;
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_data_out;
  logic [1:0]               out_status;
  logic [OCC_W-1:0]         out_occupancy;

  // shadow of the deque contents
  logic signed [WORD_W-1:0] shadow_store [DEPTH];
  logic [IDX_W-1:0]         shadow_front = '0;
  logic [IDX_W-1:0]         shadow_rear = '0;
  int                       shadow_count = 0;

  deque_result_t expected_results[$];
  bit            fixed_pending = 1'b0;
  deque_result_t fixed_result;
  int            errors = 0;

  circular_deque uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_data_out  (out_data_out),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  always #1 clk = ~clk;

  initial begin
    #100000;
    $display("testbench failed");
    $finish;
  end

  function automatic deque_result_t apply_deque_op(op_t op, logic signed [WORD_W-1:0] value);
    deque_result_t r;
    int            at;
    r.data   = '0;
    r.status = ST_DONE;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (shadow_count == DEPTH) begin
          r.status = ST_FULL;
        end else if (shadow_count == 0) begin
          shadow_front    = '0;
          shadow_rear     = '0;
          shadow_store[0] = value;
          shadow_count    = 1;
        end else if (op == OP_PUSH_FRONT) begin
          shadow_front = IDX_W'((int'(shadow_front) + DEPTH - 1) % DEPTH);
          shadow_store[shadow_front] = value;
          shadow_count++;
        end else begin
          shadow_rear = IDX_W'((int'(shadow_rear) + 1) % DEPTH);
          shadow_store[shadow_rear] = value;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          at     = (op == OP_POP_FRONT) ? int'(shadow_front) : int'(shadow_rear);
          r.data = shadow_store[at];
          if (shadow_count == 1) begin
            shadow_front = '0;
            shadow_rear  = '0;
          end else if (op == OP_POP_FRONT) begin
            shadow_front = IDX_W'((int'(shadow_front) + 1) % DEPTH);
          end else begin
            shadow_rear = IDX_W'((int'(shadow_rear) + DEPTH - 1) % DEPTH);
          end
          shadow_count--;
        end
      end
    endcase
    r.occ = OCC_W'(shadow_count);
    return r;
  endfunction

  function automatic deque_row_t stim_row(op_t op, logic signed [WORD_W-1:0] value, bit fixed,
                                          logic signed [WORD_W-1:0] data, status_t st,
                                          logic [OCC_W-1:0] occ);
    deque_row_t row;
    row.op            = op;
    row.value         = value;
    row.fixed         = fixed;
    row.result.data   = data;
    row.result.status = st;
    row.result.occ    = occ;
    return row;
  endfunction

  // results are checked before the item accepted at the same edge is predicted
  always @(posedge clk) begin : deque_monitor
    deque_result_t want;
    deque_result_t got;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result data %0d status %0d occupancy %0d",
                   $time, out_data_out, out_status, out_occupancy);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_out !== want.data) begin
            $display("%0t: data_out expected %0d got %0d", $time, want.data, out_data_out);
            errors++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
            errors++;
          end
          if (out_occupancy !== want.occ) begin
            $display("%0t: occupancy expected %0d got %0d", $time, want.occ, out_occupancy);
            errors++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        got = apply_deque_op(op_t'(in_func), in_value);
        expected_results.push_back(fixed_pending ? fixed_result : got);
      end
    end
  end

  task automatic issue_item(op_t op, logic signed [WORD_W-1:0] value, bit fixed,
                            deque_result_t res);
    start         <= 1'b1;
    in_func       <= op;
    in_value      <= value;
    fixed_pending <= fixed;
    fixed_result  <= res;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic idle_gap(bit allowed);
    if (allowed) begin
      while ($urandom_range(99) < 28) begin
        start    <= 1'b0;
        in_func  <= 2'($urandom);
        in_value <= $urandom;
        @(negedge clk);
      end
    end
  endtask

  initial begin : stimulus
    deque_row_t               rows[$];
    deque_result_t            none;
    op_t                      op;
    logic signed [WORD_W-1:0] value;
    int                       push_share;
    int                       n;

    none.data   = '0;
    none.status = ST_DONE;
    none.occ    = '0;

    rows.push_back(stim_row(OP_POP_FRONT,  32'sd0,           1, 32'sd0, ST_EMPTY, 4'd0));
    rows.push_back(stim_row(OP_PUSH_FRONT, 32'sh7fffffff,    0, 32'sd0, ST_DONE,  4'd0));
    rows.push_back(stim_row(OP_POP_REAR,   32'sd0,           1, 32'sh7fffffff, ST_DONE, 4'd0));
    rows.push_back(stim_row(OP_PUSH_REAR,  32'sh80000000,    0, 32'sd0, ST_DONE,  4'd0));
    rows.push_back(stim_row(OP_PUSH_FRONT, -32'sd1,          0, 32'sd0, ST_DONE,  4'd0));
    rows.push_back(stim_row(OP_PUSH_FRONT, 32'sd0,           0, 32'sd0, ST_DONE,  4'd0));
    rows.push_back(stim_row(OP_PUSH_REAR,  32'sd1,           0, 32'sd0, ST_DONE,  4'd0));
    rows.push_back(stim_row(OP_PUSH_REAR,  32'sh55555555,    0, 32'sd0, ST_DONE,  4'd0));
    rows.push_back(stim_row(OP_PUSH_FRONT, 32'shaaaaaaaa,    0, 32'sd0, ST_DONE,  4'd0));
    rows.push_back(stim_row(OP_PUSH_REAR,  32'sd123,         0, 32'sd0, ST_DONE,  4'd0));
    rows.push_back(stim_row(OP_PUSH_FRONT, -32'sd7,          0, 32'sd0, ST_DONE,  4'd0));
    // now full
    rows.push_back(stim_row(OP_PUSH_REAR,  32'sd5,           1, 32'sd0, ST_FULL,  4'd8));
    rows.push_back(stim_row(OP_PUSH_FRONT, 32'sd6,           1, 32'sd0, ST_FULL,  4'd8));
    repeat (4) begin
      rows.push_back(stim_row(OP_POP_FRONT, 32'sd0,          0, 32'sd0, ST_DONE,  4'd0));
      rows.push_back(stim_row(OP_POP_REAR,  32'sd0,          0, 32'sd0, ST_DONE,  4'd0));
    end
    // last word popped from the front while it sits at the top index
    rows.push_back(stim_row(OP_PUSH_FRONT, 32'sd9,           0, 32'sd0, ST_DONE,  4'd0));
    rows.push_back(stim_row(OP_PUSH_FRONT, 32'sd10,          0, 32'sd0, ST_DONE,  4'd0));
    rows.push_back(stim_row(OP_POP_REAR,   32'sd0,           0, 32'sd0, ST_DONE,  4'd0));
    rows.push_back(stim_row(OP_POP_FRONT,  32'sd0,           0, 32'sd0, ST_DONE,  4'd0));
    rows.push_back(stim_row(OP_POP_REAR,   32'sd0,           1, 32'sd0, ST_EMPTY, 4'd0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      idle_gap(1'b1);
      issue_item(rows[i].op, rows[i].value, rows[i].fixed, rows[i].result);
    end

    // phases lean towards filling, draining or neither so both ends are reached often
    push_share = 50;
    for (n = 0; n < 1400; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_share = 75;
          1:       push_share = 25;
          default: push_share = 50;
        endcase
      end
      if ($urandom_range(99) < push_share) begin
        op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
      end
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0:       value = 32'sh7fffffff;
          1:       value = 32'sh80000000;
          2:       value = -32'sd1;
          default: value = 32'sd0;
        endcase
      end else begin
        value = $urandom;
      end
      idle_gap(!(n >= 500 && n < 800));
      issue_item(op, value, 1'b0, none);
    end

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
